### rtl/teq_pkg.sv
package teq_pkg;

    localparam int QUEUE_DEPTH  = 16;
    localparam int DEVICE_COUNT = 64;
    localparam int TIME_BITS    = 48;
    localparam int MAX_RESULTS  = 16;

    localparam int DEV_BITS  = $clog2(DEVICE_COUNT);
    localparam int IDX_BITS  = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS  = $clog2(QUEUE_DEPTH + 1);
    localparam int NRES_BITS = $clog2(MAX_RESULTS);

    typedef enum logic [2:0] {
        MODE_INSERT     = 3'd0,
        MODE_REMOVE_ONE = 3'd1,
        MODE_REMOVE_ALL = 3'd2,
        MODE_QUERY      = 3'd3,
        MODE_LIST       = 3'd4,
        MODE_FIRE       = 3'd5
    } t_mode;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_FULL = 2'd1,
        STAT_PAST = 2'd2,
        STAT_NONE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_INSERT,
        CMD_REMOVE,
        CMD_POP
    } t_cell_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [TIME_BITS-1:0] stamp;
        logic [DEV_BITS-1:0]  dev;
    } t_slot;

    typedef struct packed {
        t_cell_cmd cmd;
        t_slot     key;
    } t_cell_ctl;

    typedef struct packed {
        logic [2:0]           mode;
        logic [TIME_BITS-1:0] event_time;
        logic [DEV_BITS-1:0]  device_id;
    } t_in;

    typedef struct packed {
        logic [1:0]           status;
        logic [DEV_BITS-1:0]  out_device;
        logic [TIME_BITS-1:0] out_time;
        logic                 found;
        logic [TIME_BITS-1:0] next_due;
        logic [TIME_BITS-1:0] now_time;
        logic                 last;
    } t_out;

    typedef struct packed {
        t_status              status;
        logic [DEV_BITS-1:0]  out_device;
        logic [TIME_BITS-1:0] out_time;
        logic                 found;
        logic                 last;
    } t_result;

endpackage

### rtl/timed_event_queue.sv
// Sorted event queue built as a row of slot cells, slot 0 holding the earliest
// event; each cell compares its own entry with the key and shifts to or from
// its neighbor. Insert, remove-one, query, fire and unused modes pass through
// one execute state across the cell row and one emit state that loads the
// output register, and the next item is taken in the cycle its result is
// loaded. Remove-all removes one matching entry per execute cycle and stays
// in the execute state until no matching entry is left. List produces one
// result per execute and emit pass, at most 16 results, and waits while the
// output register is still full. Every result carries the earliest pending
// time and the current time after the operation.
module timed_event_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  teq_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output teq_pkg::t_out o_out_data
);
    import teq_pkg::*;

    t_state                r_state, n_state;
    t_mode                 r_mode, n_mode;
    logic [TIME_BITS-1:0]  r_time, n_time;
    logic [DEV_BITS-1:0]   r_dev, n_dev;
    logic [CNT_BITS-1:0]   r_count, n_count;
    logic [TIME_BITS-1:0]  r_now, n_now;
    logic                  r_any, n_any;
    logic [NRES_BITS-1:0]  r_nres, n_nres;
    logic [IDX_BITS-1:0]   r_pos, n_pos;
    t_result               r_res, n_res;
    logic                  r_out_valid, n_out_valid;
    t_out                  r_out, n_out;

    t_cell_ctl             w_ctl;
    t_cell_cmd             w_cmd;
    t_slot                 w_slot  [QUEUE_DEPTH];
    t_slot                 w_left  [QUEUE_DEPTH];
    t_slot                 w_right [QUEUE_DEPTH];
    logic                  w_lafter[QUEUE_DEPTH];
    logic                  w_after [QUEUE_DEPTH];
    logic                  w_match [QUEUE_DEPTH];
    logic                  w_occ   [QUEUE_DEPTH];
    logic                  w_excl  [QUEUE_DEPTH];
    logic [1:0]            w_seen  [QUEUE_DEPTH+1];

    t_slot                 sel_slot;
    logic [IDX_BITS-1:0]   sel_idx;
    logic                  any_match;
    logic                  multi_match;
    logic                  emit_go;
    logic                  list_more;
    logic                  in_xfer;

    assign w_ctl.cmd       = w_cmd;
    assign w_ctl.key.stamp = r_time;
    assign w_ctl.key.dev   = r_dev;
    assign w_seen[0]       = 2'd0;

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            if (g == 0) begin : g_head
                assign w_left[g]   = '0;
                assign w_lafter[g] = 1'b0;
            end else begin : g_body
                assign w_left[g]   = w_slot[g-1];
                assign w_lafter[g] = w_after[g-1];
            end
            if (g == QUEUE_DEPTH - 1) begin : g_tail
                assign w_right[g] = '0;
            end else begin : g_inner
                assign w_right[g] = w_slot[g+1];
            end
            assign w_occ[g]  = CNT_BITS'(g) < r_count;
            // list resumes past the last reported entry
            assign w_excl[g] = (r_mode == MODE_LIST) && (r_nres != '0)
                               && (IDX_BITS'(g) <= r_pos);

            teq_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (w_ctl),
                .i_occ        (w_occ[g]),
                .i_excl       (w_excl[g]),
                .i_left       (w_left[g]),
                .i_left_after (w_lafter[g]),
                .i_right      (w_right[g]),
                .i_seen       (w_seen[g]),
                .o_slot       (w_slot[g]),
                .o_after      (w_after[g]),
                .o_match      (w_match[g]),
                .o_seen       (w_seen[g+1])
            );
        end
    endgenerate

    // first matching entry, one-hot select
    always_comb begin
        sel_slot = '0;
        sel_idx  = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (w_match[i] && w_seen[i] == 2'd0) begin
                sel_slot = t_slot'(sel_slot | w_slot[i]);
                sel_idx  = sel_idx | IDX_BITS'(i);
            end
        end
    end

    assign any_match   = w_seen[QUEUE_DEPTH] != 2'd0;
    assign multi_match = w_seen[QUEUE_DEPTH] == 2'd2;

    assign emit_go    = (r_state == ST_EMIT) && (!r_out_valid || i_out_ready);
    assign list_more  = (r_mode == MODE_LIST) && !r_res.last;
    assign o_in_ready = (r_state == ST_IDLE) || (emit_go && !list_more);
    assign in_xfer    = i_in_valid && o_in_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_time      = r_time;
        n_dev       = r_dev;
        n_count     = r_count;
        n_now       = r_now;
        n_any       = r_any;
        n_nres      = r_nres;
        n_pos       = r_pos;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        w_cmd       = CMD_HOLD;

        unique case (r_state)
            ST_IDLE: begin
                n_state = ST_IDLE;
            end
            ST_EXEC: begin
                n_state = ST_EMIT;
                n_res   = '{status: STAT_OK, out_device: '0, out_time: '0,
                            found: 1'b0, last: 1'b1};
                unique case (r_mode)
                    MODE_INSERT: begin
                        if (r_time < r_now) begin
                            n_res.status = STAT_PAST;
                        end else if (r_count == CNT_BITS'(QUEUE_DEPTH)) begin
                            n_res.status = STAT_FULL;
                        end else begin
                            w_cmd   = CMD_INSERT;
                            n_count = r_count + CNT_BITS'(1);
                        end
                    end
                    MODE_REMOVE_ONE: begin
                        if (any_match) begin
                            w_cmd            = CMD_REMOVE;
                            n_count          = r_count - CNT_BITS'(1);
                            n_res.out_device = r_dev;
                            n_res.out_time   = sel_slot.stamp;
                            n_res.found      = 1'b1;
                        end else begin
                            n_res.status = STAT_NONE;
                        end
                    end
                    MODE_REMOVE_ALL: begin
                        if (any_match) begin
                            // one matching entry leaves per cycle
                            w_cmd     = CMD_REMOVE;
                            n_count   = r_count - CNT_BITS'(1);
                            n_any     = 1'b1;
                            n_state   = ST_EXEC;
                        end else if (r_any) begin
                            n_res.out_device = r_dev;
                            n_res.found      = 1'b1;
                        end else begin
                            n_res.status = STAT_NONE;
                        end
                    end
                    MODE_QUERY: begin
                        if (any_match) begin
                            n_res.out_device = r_dev;
                            n_res.out_time   = sel_slot.stamp;
                            n_res.found      = 1'b1;
                        end else begin
                            n_res.status = STAT_NONE;
                        end
                    end
                    MODE_LIST: begin
                        if (any_match) begin
                            n_res.out_device = r_dev;
                            n_res.out_time   = sel_slot.stamp;
                            n_res.found      = 1'b1;
                            n_res.last       = !multi_match
                                || (r_nres == NRES_BITS'(MAX_RESULTS - 1));
                            n_pos            = sel_idx;
                        end else begin
                            n_res.status = STAT_NONE;
                        end
                    end
                    MODE_FIRE: begin
                        if (w_occ[0] && w_slot[0].stamp <= r_time) begin
                            w_cmd            = CMD_POP;
                            n_count          = r_count - CNT_BITS'(1);
                            if (w_slot[0].stamp > r_now) begin
                                n_now = w_slot[0].stamp;
                            end
                            n_res.out_device = w_slot[0].dev;
                            n_res.out_time   = w_slot[0].stamp;
                            n_res.found      = 1'b1;
                        end else begin
                            n_res.status = STAT_NONE;
                        end
                    end
                    default: begin
                        n_res.status = STAT_OK;
                    end
                endcase
            end
            ST_EMIT: begin
                if (emit_go) begin
                    n_out_valid    = 1'b1;
                    n_out.status   = r_res.status;
                    n_out.out_device = r_res.out_device;
                    n_out.out_time = r_res.out_time;
                    n_out.found    = r_res.found;
                    n_out.last     = r_res.last;
                    n_out.next_due = (r_count != '0) ? w_slot[0].stamp : '1;
                    n_out.now_time = r_now;
                    if (list_more) begin
                        n_nres  = r_nres + NRES_BITS'(1);
                        n_state = ST_EXEC;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (in_xfer) begin
            n_state = ST_EXEC;
            n_mode  = t_mode'(i_in_data.mode);
            n_time  = i_in_data.event_time;
            n_dev   = i_in_data.device_id;
            n_any   = 1'b0;
            n_nres  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_now       <= '0;
            r_out_valid <= 1'b0;
            r_any       <= 1'b0;
            r_nres      <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_now       <= n_now;
            r_out_valid <= n_out_valid;
            r_any       <= n_any;
            r_nres      <= n_nres;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode <= n_mode;
        r_time <= n_time;
        r_dev  <= n_dev;
        r_pos  <= n_pos;
        r_res  <= n_res;
        r_out  <= n_out;
    end

endmodule

### rtl/teq_cell.sv
module teq_cell (
    input  logic                i_clk,
    input  teq_pkg::t_cell_ctl  i_ctl,
    input  logic                i_occ,
    input  logic                i_excl,
    input  teq_pkg::t_slot      i_left,
    input  logic                i_left_after,
    input  teq_pkg::t_slot      i_right,
    input  logic [1:0]          i_seen,
    output teq_pkg::t_slot      o_slot,
    output logic                o_after,
    output logic                o_match,
    output logic [1:0]          o_seen
);
    import teq_pkg::*;

    t_slot r_slot;
    t_slot n_slot;

    assign o_slot  = r_slot;
    assign o_match = i_occ && !i_excl && (r_slot.dev == i_ctl.key.dev);
    // empty cells count as lying after the insert point
    assign o_after = !i_occ || (r_slot.stamp > i_ctl.key.stamp);
    // saturating count of matches up to and including this cell
    assign o_seen  = (i_seen == 2'd2 || !o_match) ? i_seen : i_seen + 2'd1;

    always_comb begin
        n_slot = r_slot;
        unique case (i_ctl.cmd)
            CMD_HOLD: begin
                n_slot = r_slot;
            end
            CMD_INSERT: begin
                if (i_left_after) begin
                    n_slot = i_left;
                end else if (o_after) begin
                    n_slot = i_ctl.key;
                end
            end
            CMD_REMOVE: begin
                if (i_seen != 2'd0 || o_match) begin
                    n_slot = i_right;
                end
            end
            CMD_POP: begin
                n_slot = i_right;
            end
            default: begin
                n_slot = r_slot;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

endmodule

### tb/sv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import teq_pkg::*;

    typedef logic [TIME_BITS-1:0] t_time;

    localparam t_time       TIME_ALL_ONES = '1;
    localparam logic [2:0]  MODE_SPARE_LO = 3'd6;
    localparam logic [2:0]  MODE_SPARE_HI = 3'd7;
    localparam int          RANDOM_ITEMS  = 480;
    localparam int          HOLD_CYCLES   = 400;
    localparam int          SETTLE_CYCLES = 40;
    localparam int          CYCLE_LIMIT   = 1000000;

    typedef struct {
        t_in  item;
        bit   typed;
        t_out want;
    } t_stim_row;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    t_in  in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out out_data;

    // scheduler state mirrored by the testbench
    t_time               slot_stamp [QUEUE_DEPTH];
    logic [DEV_BITS-1:0] slot_owner [QUEUE_DEPTH];
    int                  slot_count = 0;
    t_time               sched_now = '0;

    t_out awaited_replies [$];
    t_out op_replies [$];

    int error_count = 0;
    int reply_count = 0;
    int items_sent = 0;
    int cycle_count = 0;
    bit no_idle = 1'b0;
    bit hold_off_req = 1'b0;

    timed_event_queue dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic void add_reply(logic [1:0] status, logic [DEV_BITS-1:0] dev,
                                      t_time stamp, logic found, logic last);
        t_out r;
        r.status     = status;
        r.out_device = dev;
        r.out_time   = stamp;
        r.found      = found;
        r.next_due   = (slot_count > 0) ? slot_stamp[0] : TIME_ALL_ONES;
        r.now_time   = sched_now;
        r.last       = last;
        op_replies.push_back(r);
    endfunction

    function automatic void drop_slot(int pos);
        for (int i = pos; i + 1 < slot_count; i++) begin
            slot_stamp[i] = slot_stamp[i+1];
            slot_owner[i] = slot_owner[i+1];
        end
        slot_count--;
    endfunction

    function automatic void apply_event_op(t_in item);
        int    pos;
        int    n;
        int    w;
        bit    any;
        bit    hit;
        t_time stamp;
        logic [DEV_BITS-1:0] dev;
        op_replies.delete();
        case (item.mode)
            MODE_INSERT: begin
                if (item.event_time < sched_now) begin
                    add_reply(STAT_PAST, '0, '0, 1'b0, 1'b1);
                end else if (slot_count >= QUEUE_DEPTH) begin
                    add_reply(STAT_FULL, '0, '0, 1'b0, 1'b1);
                end else begin
                    pos = 0;
                    // equal times go behind the ones already stored
                    while (pos < slot_count && slot_stamp[pos] <= item.event_time)
                        pos++;
                    for (int i = slot_count; i > pos; i--) begin
                        slot_stamp[i] = slot_stamp[i-1];
                        slot_owner[i] = slot_owner[i-1];
                    end
                    slot_stamp[pos] = item.event_time;
                    slot_owner[pos] = item.device_id;
                    slot_count++;
                    add_reply(STAT_OK, '0, '0, 1'b0, 1'b1);
                end
            end
            MODE_REMOVE_ONE: begin
                hit = 1'b0;
                for (int i = 0; i < slot_count && !hit; i++) begin
                    if (slot_owner[i] == item.device_id) begin
                        stamp = slot_stamp[i];
                        drop_slot(i);
                        add_reply(STAT_OK, item.device_id, stamp, 1'b1, 1'b1);
                        hit = 1'b1;
                    end
                end
                if (!hit)
                    add_reply(STAT_NONE, '0, '0, 1'b0, 1'b1);
            end
            MODE_REMOVE_ALL: begin
                w = 0;
                any = 1'b0;
                for (int i = 0; i < slot_count; i++) begin
                    if (slot_owner[i] == item.device_id) begin
                        any = 1'b1;
                    end else begin
                        slot_stamp[w] = slot_stamp[i];
                        slot_owner[w] = slot_owner[i];
                        w++;
                    end
                end
                slot_count = w;
                if (any)
                    add_reply(STAT_OK, item.device_id, '0, 1'b1, 1'b1);
                else
                    add_reply(STAT_NONE, '0, '0, 1'b0, 1'b1);
            end
            MODE_QUERY: begin
                hit = 1'b0;
                for (int i = 0; i < slot_count && !hit; i++) begin
                    if (slot_owner[i] == item.device_id) begin
                        add_reply(STAT_OK, item.device_id, slot_stamp[i], 1'b1, 1'b1);
                        hit = 1'b1;
                    end
                end
                if (!hit)
                    add_reply(STAT_NONE, '0, '0, 1'b0, 1'b1);
            end
            MODE_LIST: begin
                n = 0;
                for (int i = 0; i < slot_count && n < MAX_RESULTS; i++) begin
                    if (slot_owner[i] == item.device_id) begin
                        add_reply(STAT_OK, item.device_id, slot_stamp[i], 1'b1, 1'b0);
                        n++;
                    end
                end
                if (n == 0)
                    add_reply(STAT_NONE, '0, '0, 1'b0, 1'b1);
                else
                    op_replies[n-1].last = 1'b1;
            end
            MODE_FIRE: begin
                if (slot_count > 0 && slot_stamp[0] <= item.event_time) begin
                    stamp = slot_stamp[0];
                    dev   = slot_owner[0];
                    if (stamp > sched_now)
                        sched_now = stamp;
                    drop_slot(0);
                    add_reply(STAT_OK, dev, stamp, 1'b1, 1'b1);
                end else begin
                    add_reply(STAT_NONE, '0, '0, 1'b0, 1'b1);
                end
            end
            default: begin
                add_reply(STAT_OK, '0, '0, 1'b0, 1'b1);
            end
        endcase
    endfunction

    function automatic t_stim_row plain_row(logic [2:0] mode, t_time stamp,
                                            logic [DEV_BITS-1:0] dev);
        t_stim_row r;
        r.item.mode       = mode;
        r.item.event_time = stamp;
        r.item.device_id  = dev;
        r.typed           = 1'b0;
        r.want            = '0;
        return r;
    endfunction

    function automatic t_stim_row checked_row(logic [2:0] mode, t_time stamp,
                                              logic [DEV_BITS-1:0] dev, logic [1:0] status,
                                              logic [DEV_BITS-1:0] odev, t_time otime,
                                              logic found, t_time next_due, t_time now);
        t_stim_row r;
        r = plain_row(mode, stamp, dev);
        r.typed           = 1'b1;
        r.want.status     = status;
        r.want.out_device = odev;
        r.want.out_time   = otime;
        r.want.found      = found;
        r.want.next_due   = next_due;
        r.want.now_time   = now;
        r.want.last       = 1'b1;
        return r;
    endfunction

    function automatic t_time rand_time();
        return t_time'({$urandom(), $urandom()});
    endfunction

    function automatic t_time near_future(int span);
        return sched_now + t_time'($urandom_range(0, span));
    endfunction

    function automatic logic [DEV_BITS-1:0] rand_dev();
        if ($urandom_range(0, 9) < 7)
            return DEV_BITS'($urandom_range(0, 3));
        return DEV_BITS'($urandom_range(0, DEVICE_COUNT - 1));
    endfunction

    function automatic t_stim_row random_op();
        int         pick;
        int         spread;
        logic [2:0] mode;
        t_time      stamp;
        pick   = $urandom_range(0, 99);
        spread = $urandom_range(0, 99);
        if (pick < 35)      mode = MODE_INSERT;
        else if (pick < 45) mode = MODE_REMOVE_ONE;
        else if (pick < 52) mode = MODE_REMOVE_ALL;
        else if (pick < 62) mode = MODE_QUERY;
        else if (pick < 72) mode = MODE_LIST;
        else if (pick < 96) mode = MODE_FIRE;
        else                mode = $urandom_range(0, 1) ? MODE_SPARE_LO : MODE_SPARE_HI;
        if (mode == MODE_INSERT) begin
            if (spread < 70)
                stamp = near_future(500);
            else if (spread < 80 && sched_now > 100)
                stamp = sched_now - t_time'($urandom_range(1, 100));
            else if (spread < 84)
                stamp = rand_time();
            else
                stamp = sched_now;
        end else if (mode == MODE_FIRE) begin
            if (spread < 50)      stamp = near_future(500);
            else if (spread < 65) stamp = TIME_ALL_ONES;
            else if (spread < 80) stamp = rand_time();
            else                  stamp = sched_now;
        end else begin
            stamp = rand_time();
        end
        return plain_row(mode, stamp, rand_dev());
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH reply %0d at cycle %0d: %s", reply_count, cycle_count, msg);
        error_count++;
    endtask

    task automatic check_reply(t_out got);
        t_out want;
        if (awaited_replies.size() == 0) begin
            report_mismatch("reply with nothing outstanding");
            return;
        end
        want = awaited_replies.pop_front();
        if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
        if (got.out_device !== want.out_device)
            report_mismatch($sformatf("out_device %0d, want %0d",
                                      got.out_device, want.out_device));
        if (got.out_time !== want.out_time)
            report_mismatch($sformatf("out_time %h, want %h", got.out_time, want.out_time));
        if (got.found !== want.found)
            report_mismatch($sformatf("found %b, want %b", got.found, want.found));
        if (got.next_due !== want.next_due)
            report_mismatch($sformatf("next_due %h, want %h", got.next_due, want.next_due));
        if (got.now_time !== want.now_time)
            report_mismatch($sformatf("now_time %h, want %h", got.now_time, want.now_time));
        if (got.last !== want.last)
            report_mismatch($sformatf("last %b, want %b", got.last, want.last));
    endtask

    task automatic send_item(t_stim_row row);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= row.item;
        do @(posedge clk); while (!in_ready);
        apply_event_op(row.item);
        if (row.typed) begin
            awaited_replies.push_back(row.want);
        end else begin
            foreach (op_replies[i])
                awaited_replies.push_back(op_replies[i]);
        end
        items_sent++;
    endtask

    // receiver side: random stall per reply, plus one long hold-off on request
    initial begin
        int wait_left;
        wait_left = 0;
        forever begin
            @(posedge clk);
            if (out_ready && out_valid) begin
                check_reply(out_data);
                reply_count++;
                wait_left = no_idle ? 0 : $urandom_range(0, 15);
            end
            if (hold_off_req) begin
                wait_left = HOLD_CYCLES;
                hold_off_req = 1'b0;
            end
            if (wait_left > 0) begin
                out_ready <= 1'b0;
                wait_left--;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    initial begin
        t_stim_row           directed_rows [$];
        t_stim_row           r;
        int                  seg;
        int                  fill_len;
        bit                  solo;
        bit                  hold_done;
        logic [DEV_BITS-1:0] base_dev;

        hold_done = 1'b0;

        // empty table right after reset
        directed_rows.push_back(checked_row(MODE_FIRE, '0, '0, STAT_NONE, '0, '0, 1'b0,
                                            TIME_ALL_ONES, '0));
        directed_rows.push_back(checked_row(MODE_QUERY, '0, '0, STAT_NONE, '0, '0, 1'b0,
                                            TIME_ALL_ONES, '0));
        directed_rows.push_back(checked_row(MODE_REMOVE_ONE, TIME_ALL_ONES, 6'd63, STAT_NONE,
                                            '0, '0, 1'b0, TIME_ALL_ONES, '0));
        directed_rows.push_back(checked_row(MODE_REMOVE_ALL, '0, 6'd5, STAT_NONE, '0, '0,
                                            1'b0, TIME_ALL_ONES, '0));
        directed_rows.push_back(checked_row(MODE_LIST, '0, '0, STAT_NONE, '0, '0, 1'b0,
                                            TIME_ALL_ONES, '0));
        directed_rows.push_back(checked_row(MODE_SPARE_LO, '0, '0, STAT_OK, '0, '0, 1'b0,
                                            TIME_ALL_ONES, '0));
        directed_rows.push_back(checked_row(MODE_SPARE_HI, TIME_ALL_ONES, 6'd63, STAT_OK,
                                            '0, '0, 1'b0, TIME_ALL_ONES, '0));
        // time extremes
        directed_rows.push_back(checked_row(MODE_INSERT, TIME_ALL_ONES, 6'd63, STAT_OK, '0,
                                            '0, 1'b0, TIME_ALL_ONES, '0));
        directed_rows.push_back(checked_row(MODE_QUERY, '0, 6'd63, STAT_OK, 6'd63,
                                            TIME_ALL_ONES, 1'b1, TIME_ALL_ONES, '0));
        directed_rows.push_back(checked_row(MODE_INSERT, '0, '0, STAT_OK, '0, '0, 1'b0,
                                            '0, '0));
        // equal times keep their insertion order
        directed_rows.push_back(plain_row(MODE_INSERT, 48'd100, 6'd1));
        directed_rows.push_back(plain_row(MODE_INSERT, 48'd100, 6'd2));
        directed_rows.push_back(plain_row(MODE_INSERT, 48'd50, 6'd1));
        directed_rows.push_back(plain_row(MODE_LIST, '0, 6'd1));
        directed_rows.push_back(plain_row(MODE_FIRE, 48'd99, '0));
        directed_rows.push_back(plain_row(MODE_FIRE, 48'd99, '0));
        // insert behind current time
        directed_rows.push_back(checked_row(MODE_INSERT, 48'd49, 6'd3, STAT_PAST, '0, '0,
                                            1'b0, 48'd100, 48'd50));
        directed_rows.push_back(plain_row(MODE_FIRE, 48'd60, '0));
        directed_rows.push_back(plain_row(MODE_FIRE, TIME_ALL_ONES, '0));
        directed_rows.push_back(plain_row(MODE_REMOVE_ONE, '0, 6'd2));
        directed_rows.push_back(plain_row(MODE_REMOVE_ALL, '0, 6'd63));
        directed_rows.push_back(plain_row(MODE_INSERT, 48'd100, 6'd42));
        directed_rows.push_back(plain_row(MODE_INSERT, 48'd200, 6'd21));
        directed_rows.push_back(plain_row(MODE_REMOVE_ALL, '0, 6'd21));
        directed_rows.push_back(plain_row(MODE_FIRE, 48'd100, '0));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i]);

        while (items_sent < directed_rows.size() + RANDOM_ITEMS) begin
            seg = $urandom_range(0, 99);
            no_idle = ($urandom_range(0, 4) == 0);
            if (seg < 25 || !hold_done) begin
                // fill past capacity, list, then empty it again
                if (!hold_done) begin
                    hold_off_req = 1'b1;
                    hold_done = 1'b1;
                end
                base_dev = DEV_BITS'($urandom_range(0, DEVICE_COUNT - 1));
                solo     = $urandom_range(0, 1);
                fill_len = $urandom_range(QUEUE_DEPTH + 1, QUEUE_DEPTH + 3);
                repeat (fill_len) begin
                    r = plain_row(MODE_INSERT, near_future(300),
                                  (solo || $urandom_range(0, 3) != 0) ? base_dev : rand_dev());
                    send_item(r);
                end
                send_item(plain_row(MODE_LIST, rand_time(), base_dev));
                // past check wins over the full check
                if (sched_now > 0)
                    send_item(plain_row(MODE_INSERT, sched_now - 1, base_dev));
                if ($urandom_range(0, 1))
                    send_item(plain_row(MODE_REMOVE_ALL, rand_time(), base_dev));
                while (slot_count > 0) begin
                    r = plain_row(MODE_FIRE, $urandom_range(0, 3) == 0 ? TIME_ALL_ONES :
                                  near_future(400), rand_dev());
                    send_item(r);
                end
            end else if (seg < 85) begin
                repeat (20)
                    send_item(random_op());
            end else begin
                repeat ($urandom_range(5, QUEUE_DEPTH + 1)) begin
                    r = plain_row(MODE_FIRE, $urandom_range(0, 2) == 0 ? TIME_ALL_ONES :
                                  near_future(1000), rand_dev());
                    send_item(r);
                end
            end
        end
        in_valid <= 1'b0;
        no_idle = 1'b0;

        while (awaited_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/teq_pkg.sv
rtl/teq_cell.sv
rtl/timed_event_queue.sv
tb/sv/testbench.sv
